// ===== rtl/core/icds_pkg.sv =====
`default_nettype none

package icds_pkg;

    // item and register widths
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned IDX_W        = 5;
    localparam int unsigned FUNC_W       = 2;
    localparam int unsigned OFFSET_W     = 3;
    localparam int unsigned NUM_SOURCES  = 32;

    // decoupling queue between the bus front and the result back end
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_WRITE  = 2'd2,
        FUNC_SCAN   = 2'd3
    } func_t;

    // register offsets
    localparam logic [OFFSET_W-1:0] OFF_IRQSTAT   = 3'd0;
    localparam logic [OFFSET_W-1:0] OFF_FIQSTAT   = 3'd1;
    localparam logic [OFFSET_W-1:0] OFF_RAW       = 3'd2;
    localparam logic [OFFSET_W-1:0] OFF_SELECT    = 3'd3;
    localparam logic [OFFSET_W-1:0] OFF_ENABLE    = 3'd4;
    localparam logic [OFFSET_W-1:0] OFF_ENCLEAR   = 3'd5;
    localparam logic [OFFSET_W-1:0] OFF_SOFT      = 3'd6;
    localparam logic [OFFSET_W-1:0] OFF_SOFTCLEAR = 3'd7;

    // one classified item handed from front to back
    // data is the read value for a single result, or the irq pending mask for a scan
    typedef struct packed {
        logic              scan;
        logic [DATA_W-1:0] data;
        logic              irq;
        logic              fiq;
    } q_entry_t;

    // lowest set bit of a word, zero when the word is empty
    function automatic logic [IDX_W-1:0] lowest_index(input logic [DATA_W-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = DATA_W - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/icds_front.sv =====
`default_nettype none

module icds_front #(
    parameter int unsigned NUM_SOURCES = icds_pkg::NUM_SOURCES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [icds_pkg::FUNC_W-1:0]     func,
    input  wire logic [icds_pkg::OFFSET_W-1:0]   reg_offset,
    input  wire logic [icds_pkg::DATA_W-1:0]     write_data,
    input  wire logic [icds_pkg::DATA_W-1:0]     source_lines,
    output logic                                 push,
    output icds_pkg::q_entry_t                   push_entry,
    input  wire logic                            q_full
);

    logic [NUM_SOURCES-1:0] latched_reg, latched_next;
    logic [NUM_SOURCES-1:0] select_reg,  select_next;
    logic [NUM_SOURCES-1:0] enable_reg,  enable_next;
    logic [NUM_SOURCES-1:0] soft_reg,    soft_next;

    logic [NUM_SOURCES-1:0] wd;
    logic [NUM_SOURCES-1:0] lines;
    logic [NUM_SOURCES-1:0] raw_cur, irq_cur, fiq_cur;
    logic [NUM_SOURCES-1:0] raw_new, irq_new, fiq_new;
    logic [NUM_SOURCES-1:0] result_mask;
    logic [icds_pkg::DATA_W-1:0] result_ext;
    logic                   accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept;

    assign wd    = write_data[NUM_SOURCES-1:0];
    assign lines = source_lines[NUM_SOURCES-1:0];

    // status before this item
    assign raw_cur = latched_reg | soft_reg;
    assign irq_cur = raw_cur & enable_reg & ~select_reg;
    assign fiq_cur = raw_cur & enable_reg & select_reg;

    // register file update and read selection
    always_comb
    begin
        latched_next = latched_reg;
        select_next  = select_reg;
        enable_next  = enable_reg;
        soft_next    = soft_reg;
        result_mask  = '0;
        case (icds_pkg::func_t'(func))
            icds_pkg::FUNC_SAMPLE:
            begin
                latched_next = lines;
            end
            icds_pkg::FUNC_READ:
            begin
                case (reg_offset)
                    icds_pkg::OFF_IRQSTAT: result_mask = irq_cur;
                    icds_pkg::OFF_FIQSTAT: result_mask = fiq_cur;
                    icds_pkg::OFF_RAW:     result_mask = raw_cur;
                    icds_pkg::OFF_SELECT:  result_mask = select_reg;
                    icds_pkg::OFF_ENABLE:  result_mask = enable_reg;
                    default:               result_mask = '0;
                endcase
            end
            icds_pkg::FUNC_WRITE:
            begin
                case (reg_offset)
                    icds_pkg::OFF_SELECT:    select_next = wd;
                    icds_pkg::OFF_ENABLE:    enable_next = enable_reg | wd;
                    icds_pkg::OFF_ENCLEAR:   enable_next = enable_reg & ~wd;
                    icds_pkg::OFF_SOFT:      soft_next   = soft_reg | wd;
                    icds_pkg::OFF_SOFTCLEAR: soft_next   = soft_reg & ~wd;
                    default:                 ;
                endcase
            end
            icds_pkg::FUNC_SCAN:
            begin
                result_mask = irq_cur;
            end
            default:
            begin
                result_mask = '0;
            end
        endcase
    end

    // status after this item drives the output lines
    assign raw_new = latched_next | soft_next;
    assign irq_new = raw_new & enable_next & ~select_next;
    assign fiq_new = raw_new & enable_next & select_next;

    always_comb
    begin
        result_ext = '0;
        result_ext[NUM_SOURCES-1:0] = result_mask;
    end

    always_comb
    begin
        push_entry.scan = (icds_pkg::func_t'(func) == icds_pkg::FUNC_SCAN);
        push_entry.data = result_ext;
        push_entry.irq  = |irq_new;
        push_entry.fiq  = |fiq_new;
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg <= '0;
            select_reg  <= '0;
            enable_reg  <= '0;
            soft_reg    <= '0;
        end
        else if (accept)
        begin
            latched_reg <= latched_next;
            select_reg  <= select_next;
            enable_reg  <= enable_next;
            soft_reg    <= soft_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/icds_queue.sv =====
`default_nettype none

module icds_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire icds_pkg::q_entry_t push_entry,
    output logic                    full,
    output logic                    q_valid,
    output icds_pkg::q_entry_t      q_entry,
    input  wire logic               pop
);

    localparam logic [icds_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        icds_pkg::QUEUE_PTR_W'(icds_pkg::QUEUE_DEPTH - 1);
    localparam logic [icds_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
        icds_pkg::QUEUE_CNT_W'(icds_pkg::QUEUE_DEPTH);

    icds_pkg::q_entry_t entry_reg [icds_pkg::QUEUE_DEPTH];

    logic [icds_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [icds_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [icds_pkg::QUEUE_CNT_W-1:0] count_reg,  count_next;
    logic                             do_push, do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign q_valid = (count_reg != '0);
    assign q_entry = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0
                        : wr_ptr_reg + icds_pkg::QUEUE_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0
                        : rd_ptr_reg + icds_pkg::QUEUE_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + icds_pkg::QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - icds_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue fill count above depth");

    a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/icds_back.sv =====
`default_nettype none

module icds_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    input  wire icds_pkg::q_entry_t             q_entry,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [icds_pkg::DATA_W-1:0]         read_data,
    output logic                                irq_line,
    output logic                                fiq_line,
    output logic [icds_pkg::IDX_W-1:0]          pending_index,
    output logic                                pending_valid,
    output logic                                last
);

    // scan control
    logic [icds_pkg::DATA_W-1:0] rem_reg,   rem_next;
    logic                        out_valid_reg, out_valid_next;

    // held lines of the scan in progress
    logic hold_irq_reg, hold_irq_next;
    logic hold_fiq_reg, hold_fiq_next;

    // output register
    logic [icds_pkg::DATA_W-1:0] read_data_reg, read_data_next;
    logic                        irq_reg,       irq_next;
    logic                        fiq_reg,       fiq_next;
    logic [icds_pkg::IDX_W-1:0]  index_reg,     index_next;
    logic                        pvalid_reg,    pvalid_next;
    logic                        last_reg,      last_next;

    logic                        scanning;
    logic                        out_free;
    logic [icds_pkg::DATA_W-1:0] src;
    logic [icds_pkg::DATA_W-1:0] bit_mask;
    logic [icds_pkg::DATA_W-1:0] rest;
    logic [icds_pkg::IDX_W-1:0]  idx;

    assign scanning = (rem_reg != '0);
    assign out_free = !out_valid_reg || !out_stall;

    // pick the lowest pending source of the scan word
    assign src      = scanning ? rem_reg : q_entry.data;
    assign idx      = icds_pkg::lowest_index(src);
    assign bit_mask = icds_pkg::DATA_W'(1) << idx;
    assign rest     = src & ~bit_mask;

    // result sequencing
    always_comb
    begin
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        hold_irq_next  = hold_irq_reg;
        hold_fiq_next  = hold_fiq_reg;
        read_data_next = read_data_reg;
        irq_next       = irq_reg;
        fiq_next       = fiq_reg;
        index_next     = index_reg;
        pvalid_next    = pvalid_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (out_free)
        begin
            if (scanning)
            begin
                out_valid_next = 1'b1;
                rem_next       = rest;
                read_data_next = '0;
                irq_next       = hold_irq_reg;
                fiq_next       = hold_fiq_reg;
                index_next     = idx;
                pvalid_next    = 1'b1;
                last_next      = (rest == '0);
            end
            else if (q_valid)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                irq_next       = q_entry.irq;
                fiq_next       = q_entry.fiq;
                if (q_entry.scan && (q_entry.data != '0))
                begin
                    rem_next       = rest;
                    hold_irq_next  = q_entry.irq;
                    hold_fiq_next  = q_entry.fiq;
                    read_data_next = '0;
                    index_next     = idx;
                    pvalid_next    = 1'b1;
                    last_next      = (rest == '0);
                end
                else
                begin
                    read_data_next = q_entry.scan ? '0 : q_entry.data;
                    index_next     = '0;
                    pvalid_next    = 1'b0;
                    last_next      = 1'b1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_irq_reg  <= hold_irq_next;
        hold_fiq_reg  <= hold_fiq_next;
        read_data_reg <= read_data_next;
        irq_reg       <= irq_next;
        fiq_reg       <= fiq_next;
        index_reg     <= index_next;
        pvalid_reg    <= pvalid_next;
        last_reg      <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign irq_line      = irq_reg;
    assign fiq_line      = fiq_reg;
    assign pending_index = index_reg;
    assign pending_valid = pvalid_reg;
    assign last          = last_reg;

`ifndef SYNTHESIS
    a_scan_shown: assert property (@(posedge clk) disable iff (!rst_n)
        scanning |-> out_valid_reg && pvalid_reg && !last_reg)
        else $error("scan in progress without a shown pending index");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pvalid_reg |-> last_reg)
        else $error("non-scan result without last");

    a_no_pop_midscan: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !scanning && out_free)
        else $error("queue popped while a scan is still running");

    a_scan_irq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pvalid_reg |-> irq_reg)
        else $error("pending index shown with irq line low");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/interrupt_controller_with_dispatch_scan.sv =====
// timing: an accepted item is written into the queue at the accepting edge; it moves
//   into the result register of the back end once that register is free and no scan
//   is running, while new items are still accepted as long as the queue has room
// results: sample, read and write items give one result each; a dispatch scan
//   gives one result per pending irq source (one if none)
// reset: asynchronous, clears all interrupt registers, the queue and the output valid
`default_nettype none

module interrupt_controller_with_dispatch_scan #(
    parameter int unsigned NUM_SOURCES = icds_pkg::NUM_SOURCES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [icds_pkg::FUNC_W-1:0]     func,
    input  wire logic [icds_pkg::OFFSET_W-1:0]   reg_offset,
    input  wire logic [icds_pkg::DATA_W-1:0]     write_data,
    input  wire logic [icds_pkg::DATA_W-1:0]     source_lines,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [icds_pkg::DATA_W-1:0]          read_data,
    output logic                                 irq_line,
    output logic                                 fiq_line,
    output logic [icds_pkg::IDX_W-1:0]           pending_index,
    output logic                                 pending_valid,
    output logic                                 last
);

    logic               push;
    icds_pkg::q_entry_t push_entry;
    logic               q_full;
    logic               q_valid;
    icds_pkg::q_entry_t q_entry;
    logic               pop;

    // register file and item classification
    icds_front #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .reg_offset   (reg_offset),
        .write_data   (write_data),
        .source_lines (source_lines),
        .push         (push),
        .push_entry   (push_entry),
        .q_full       (q_full)
    );

    // decoupling queue
    icds_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop)
    );

    // result sequencing and dispatch scan
    icds_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_data     (read_data),
        .irq_line      (irq_line),
        .fiq_line      (fiq_line),
        .pending_index (pending_index),
        .pending_valid (pending_valid),
        .last          (last)
    );

endmodule

`default_nettype wire
